// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, muted while reset is high.
`define TLU8V_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define TLU8V_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tlu8v_pkg.sv =====
// Types and constants for the typed leaf UTF-8 validator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package tlu8v_pkg;

   localparam int unsigned MAX_LEAF = 1024;

   localparam logic [2:0] KIND_BOOL    = 3'd0;
   localparam logic [2:0] KIND_ADDRESS = 3'd1;
   localparam logic [2:0] KIND_STRING  = 3'd2;
   localparam logic [2:0] KIND_BYTES   = 3'd3;
   localparam logic [2:0] KIND_UINT    = 3'd4;
   localparam logic [2:0] KIND_INT     = 3'd5;

   localparam logic [15:0] ADDRESS_LEN = 16'd20;
   localparam logic [15:0] INT_MAX_LEN = 16'd32;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [20:0] CP_MIN_2    = 21'h80;
   localparam logic [20:0] CP_MIN_3    = 21'h800;
   localparam logic [20:0] CP_MIN_4    = 21'h10000;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'hD800;
   localparam logic [20:0] SURR_HI     = 21'hDFFF;

   typedef struct packed {
      logic [2:0]  data_kind;
      logic        size_given;
      logic [15:0] declared_size;
      logic [7:0]  value_byte;
      logic        has_byte;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic        leaf_ok;
      logic [15:0] leaf_length;
   } rsp_type;

   // Control from the input stage to the leaf engine and the result register.
   typedef struct packed {
      logic fire;
      logic is_last;
   } step_type;

   typedef struct packed {
      logic        in_leaf;
      logic [2:0]  kind;
      logic        size_flag;
      logic [15:0] size;
      logic [15:0] count;
      logic        overflow;
      logic [1:0]  pending;
      logic [1:0]  extra;
      logic [20:0] acc;
      logic        text_bad;
      logic        bool_bad;
   } leaf_state_type;

endpackage

// ===== rtl/tlu8v_in_reg.sv =====
// Input register stage: captures one request beat and holds it until it moves on.
// Depends on tlu8v_pkg.
`timescale 1ns / 1ps
module tlu8v_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tlu8v_pkg::req_type req_data,
   input  logic              out_ready,
   output tlu8v_pkg::step_type step,
   output tlu8v_pkg::req_type item
);
   import tlu8v_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    advance;
   logic    accept;

   // A last beat moves on only when the result register can take its verdict.
   assign advance   = !data_ff.is_last || out_ready;
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign step.fire    = valid_ff && advance;
   assign step.is_last = data_ff.is_last;
   assign item         = data_ff;

endmodule

// ===== rtl/tlu8v_leaf_engine.sv =====
// Leaf engine: per-byte count, bool and UTF-8 state, and the type verdict.
// Depends on tlu8v_pkg.
`timescale 1ns / 1ps
module tlu8v_leaf_engine #(
   parameter int unsigned MAX_LEAF = tlu8v_pkg::MAX_LEAF
) (
   input  logic               clock,
   input  logic               reset,
   input  tlu8v_pkg::step_type step,
   input  tlu8v_pkg::req_type  item,
   output tlu8v_pkg::rsp_type  verdict
);
   import tlu8v_pkg::*;

   localparam logic [16:0] MaxLeafW = 17'(MAX_LEAF);

   leaf_state_type st_ff, st_in;
   leaf_state_type nx;
   logic           ok;

   always_comb begin
      logic [7:0]  c;
      logic [1:0]  pend_dec;
      logic [20:0] cp;
      c        = item.value_byte;
      pend_dec = 2'd0;
      cp       = '0;

      nx = st_ff;
      if (!st_ff.in_leaf) begin
         nx           = '0;
         nx.kind      = item.data_kind;
         nx.size_flag = item.size_given;
         nx.size      = item.declared_size;
         nx.in_leaf   = 1'b1;
      end

      if (item.has_byte) begin
         if (nx.count == 16'd0 && c > 8'd1) begin
            nx.bool_bad = 1'b1;
         end
         if (nx.count == COUNT_MAX) begin
            nx.overflow = 1'b1;
         end else begin
            nx.count = nx.count + 16'd1;
         end

         if (!nx.text_bad) begin
            if (nx.pending != 2'd0) begin
               if (c[7:6] != 2'b10) begin
                  nx.text_bad = 1'b1;
               end else begin
                  cp         = {nx.acc[14:0], c[5:0]};
                  pend_dec   = nx.pending - 2'd1;
                  nx.acc     = cp;
                  nx.pending = pend_dec;
                  if (pend_dec == 2'd0) begin
                     if ((nx.extra == 2'd1 && cp < CP_MIN_2) ||
                         (nx.extra == 2'd2 && cp < CP_MIN_3) ||
                         (nx.extra == 2'd3 && cp < CP_MIN_4) ||
                         (cp > CP_MAX) ||
                         (cp >= SURR_LO && cp <= SURR_HI)) begin
                        nx.text_bad = 1'b1;
                     end
                  end
               end
            end else if (c < 8'h20 || c == 8'h7F) begin
               nx.text_bad = 1'b1;
            end else if (c < 8'h80) begin
               // plain ASCII, nothing to track
            end else if (c[7:5] == 3'b110) begin
               nx.extra   = 2'd1;
               nx.pending = 2'd1;
               nx.acc     = {16'd0, c[4:0]};
            end else if (c[7:4] == 4'b1110) begin
               nx.extra   = 2'd2;
               nx.pending = 2'd2;
               nx.acc     = {17'd0, c[3:0]};
            end else if (c[7:3] == 5'b11110) begin
               nx.extra   = 2'd3;
               nx.pending = 2'd3;
               nx.acc     = {18'd0, c[2:0]};
            end else begin
               nx.text_bad = 1'b1;
            end
         end
      end

      if (item.is_last) begin
         nx.in_leaf = 1'b0;
      end
   end

   always_comb begin
      ok = 1'b0;
      case (nx.kind)
         KIND_BOOL:    ok = nx.count == 16'd1 && !nx.bool_bad;
         KIND_ADDRESS: ok = nx.count == ADDRESS_LEN;
         KIND_STRING:  ok = !nx.text_bad && nx.pending == 2'd0;
         KIND_BYTES: begin
            if (nx.size_flag) begin
               ok = nx.count == nx.size;
            end else begin
               ok = {1'b0, nx.count} <= MaxLeafW;
            end
         end
         KIND_UINT, KIND_INT: begin
            ok = nx.size_flag && nx.size != 16'd0 && nx.size <= INT_MAX_LEN &&
                 nx.count == nx.size;
         end
         default: ok = 1'b0;
      endcase
      if (nx.overflow) begin
         ok = 1'b0;
      end
   end

   assign st_in = step.fire ? nx : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign verdict.leaf_ok     = ok;
   assign verdict.leaf_length = nx.count;

endmodule

// ===== rtl/tlu8v_out_reg.sv =====
// Result register: holds one verdict beat until the consumer takes it.
// Depends on tlu8v_pkg.
`timescale 1ns / 1ps
module tlu8v_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  tlu8v_pkg::step_type step,
   input  tlu8v_pkg::rsp_type  verdict,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlu8v_pkg::rsp_type  rsp_data
);
   import tlu8v_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = step.fire && step.is_last;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = verdict;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/typed_leaf_utf8_validator.sv =====
// Top level of the typed leaf validator: input register, leaf engine, result register.
// Depends on tlu8v_pkg, tlu8v_in_reg, tlu8v_leaf_engine, tlu8v_out_reg.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_data  (one value byte per beat)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data  (one verdict per leaf)
//
// One beat per cycle while req_stall is low; a verdict passes from the input register
// through the leaf engine into the result register before rsp_ can take it.
// The per-byte state update sits between the input and result registers.
// Reset (synchronous) empties both registers and clears the leaf state.
// req_stall rises only while a last beat waits behind an unaccepted verdict.
`timescale 1ns / 1ps
module typed_leaf_utf8_validator #(
   parameter int unsigned MAX_LEAF = tlu8v_pkg::MAX_LEAF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlu8v_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlu8v_pkg::rsp_type  rsp_data
);
   import tlu8v_pkg::*;

   step_type step;
   req_type  item;
   rsp_type  verdict;
   logic     out_ready;

   tlu8v_in_reg u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_ready (out_ready),
      .step      (step),
      .item      (item)
   );

   tlu8v_leaf_engine #(
      .MAX_LEAF (MAX_LEAF)
   ) u_leaf (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item),
      .verdict (verdict)
   );

   tlu8v_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .verdict   (verdict),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/tlu8v_checker.sv =====
// Port-level checks for the typed leaf validator, bound to the top level.
// Depends on tlu8v_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlu8v_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input tlu8v_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input tlu8v_pkg::rsp_type  rsp_data
);
   import tlu8v_pkg::*;

   `TLU8V_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result beat changed")
   `TLU8V_ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "result or stall after reset")
   `TLU8V_ASSERT_RST(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "request stalled with no blocked result")
   `TLU8V_ASSERT_RST(a_rsp_origin, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.is_last, 2), "verdict without a last beat")

endmodule

bind typed_leaf_utf8_validator tlu8v_checker u_chk (.*);

// ===== test/typed_leaf_utf8_validator_test.sv =====
// Self-checking bench for typed_leaf_utf8_validator: directed leaf table plus random leaves.
// Depends on tlu8v_pkg and the block RTL; verdicts are checked against the leaf table or a local leaf predictor.
`timescale 1ns / 1ps
module typed_leaf_utf8_validator_test;
   import tlu8v_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 5;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned RANDOM_BEATS = 600;
   localparam int unsigned DRAIN_CYCLES = 8;

   // data_kind codes the package leaves unnamed; both must always fail
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   typedef logic [7:0] octet_q_type[$];

   // One directed leaf. Bytes past the first four are filled with 'A'.
   typedef struct packed {
      logic [2:0]  kind;
      logic        sized;
      logic [15:0] dsize;
      int unsigned len;
      logic [31:0] lead;
      bit          typed;
      logic        ok;
   } leaf_case_type;

   localparam int N_CASES = 35;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   leaf_state_type shadow = '0;
   rsp_type        verdicts_due[$];
   bit             leaf_typed;
   rsp_type        leaf_typed_rsp;
   int unsigned    beats_sent = 0;
   int unsigned    burst_left = 0;
   int unsigned    hold_left = 0;
   int unsigned    mismatches = 0;
   int unsigned    cycles = 0;

   typed_leaf_utf8_validator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatches++;
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Advances the shadow leaf state by one beat; returns 1 with the verdict on a last beat.
   function automatic bit absorb_beat(input req_type beat, output rsp_type verdict);
      logic [7:0]  c;
      logic [20:0] cp;
      c = beat.value_byte;
      verdict = '0;
      if (!shadow.in_leaf) begin
         shadow = '0;
         shadow.kind = beat.data_kind;
         shadow.size_flag = beat.size_given;
         shadow.size = beat.declared_size;
         shadow.in_leaf = 1'b1;
      end
      if (beat.has_byte) begin
         if (shadow.count == 16'd0 && c > 8'd1)
            shadow.bool_bad = 1'b1;
         if (shadow.count == COUNT_MAX)
            shadow.overflow = 1'b1;
         else
            shadow.count++;
         if (!shadow.text_bad) begin
            if (shadow.pending != 2'd0) begin
               if (c[7:6] != 2'b10) begin
                  shadow.text_bad = 1'b1;
               end else begin
                  shadow.acc = {shadow.acc[14:0], c[5:0]};
                  shadow.pending--;
                  if (shadow.pending == 2'd0) begin
                     cp = shadow.acc;
                     if ((shadow.extra == 2'd1 && cp < CP_MIN_2) ||
                         (shadow.extra == 2'd2 && cp < CP_MIN_3) ||
                         (shadow.extra == 2'd3 && cp < CP_MIN_4) ||
                         cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI))
                        shadow.text_bad = 1'b1;
                  end
               end
            end else if (c < 8'h20 || c == 8'h7F) begin
               shadow.text_bad = 1'b1;
            end else if (c[7]) begin
               if (c[7:5] == 3'b110) begin
                  shadow.extra = 2'd1;
                  shadow.pending = 2'd1;
                  shadow.acc = {16'd0, c[4:0]};
               end else if (c[7:4] == 4'b1110) begin
                  shadow.extra = 2'd2;
                  shadow.pending = 2'd2;
                  shadow.acc = {17'd0, c[3:0]};
               end else if (c[7:3] == 5'b11110) begin
                  shadow.extra = 2'd3;
                  shadow.pending = 2'd3;
                  shadow.acc = {18'd0, c[2:0]};
               end else begin
                  shadow.text_bad = 1'b1;
               end
            end
         end
      end
      if (!beat.is_last)
         return 1'b0;
      verdict.leaf_length = shadow.count;
      if (shadow.overflow) begin
         verdict.leaf_ok = 1'b0;
      end else begin
         case (shadow.kind)
            KIND_BOOL: begin
               verdict.leaf_ok = shadow.count == 16'd1 && !shadow.bool_bad;
            end
            KIND_ADDRESS: begin
               verdict.leaf_ok = shadow.count == ADDRESS_LEN;
            end
            KIND_STRING: begin
               verdict.leaf_ok = !shadow.text_bad && shadow.pending == 2'd0;
            end
            KIND_BYTES: begin
               verdict.leaf_ok = shadow.size_flag ? shadow.count == shadow.size
                                                  : shadow.count <= MAX_LEAF;
            end
            KIND_UINT, KIND_INT: begin
               verdict.leaf_ok = shadow.size_flag && shadow.size >= 16'd1 &&
                                 shadow.size <= INT_MAX_LEN && shadow.count == shadow.size;
            end
            default: begin
               verdict.leaf_ok = 1'b0;
            end
         endcase
      end
      shadow.in_leaf = 1'b0;
      return 1'b1;
   endfunction

   // Drives one beat from a falling edge and returns at the falling edge after it is taken.
   task automatic send_beat(input req_type beat);
      rsp_type verdict;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (absorb_beat(beat, verdict))
         verdicts_due.push_back(leaf_typed ? leaf_typed_rsp : verdict);
      @(negedge clock);
   endtask

   // Sends one leaf. Only the opening beat carries the real descriptor; later beats carry
   // noise there. Short leaves get byteless filler beats, and some end on a byteless last beat.
   task automatic send_leaf(input logic [2:0] kind, input logic sized, input logic [15:0] dsize,
                            input octet_q_type body, input bit typed, input rsp_type typed_rsp);
      req_type     beat;
      logic [31:0] noise;
      int          n;
      int          pos;
      bit          opening;
      bit          split_end;
      bit          done;
      n = body.size();
      pos = 0;
      opening = 1'b1;
      done = 1'b0;
      split_end = (n == 0) || ($urandom_range(0, 7) == 0);
      leaf_typed = typed;
      leaf_typed_rsp = typed_rsp;
      while (!done) begin
         noise = $urandom;
         beat = noise[$bits(req_type)-1:0];
         if (opening) begin
            beat.data_kind = kind;
            beat.size_given = sized;
            beat.declared_size = dsize;
            opening = 1'b0;
         end
         if (n < 2000 && $urandom_range(0, 9) == 0) begin
            beat.has_byte = 1'b0;
            beat.is_last = 1'b0;
         end else begin
            beat.has_byte = pos < n;
            if (pos < n)
               beat.value_byte = body[pos];
            beat.is_last = (pos >= n) || (pos == n - 1 && !split_end);
            done = beat.is_last;
            pos++;
            beats_sent++;
         end
         send_beat(beat);
      end
   endtask

   always @(negedge clock) begin
      if (hold_left == 0) begin
         if (!rsp_stall && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(1, 8);
         end else begin
            rsp_stall <= 1'b0;
            hold_left = $urandom_range(1, 30);
         end
      end
      hold_left--;
   end

   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            flag_mismatch("verdict with none outstanding", 32'(rsp_data), 32'd0);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_data.leaf_ok !== want.leaf_ok)
               flag_mismatch("leaf_ok", 32'(rsp_data.leaf_ok), 32'(want.leaf_ok));
            if (rsp_data.leaf_length !== want.leaf_length)
               flag_mismatch("leaf_length", 32'(rsp_data.leaf_length),
                             32'(want.leaf_length));
         end
      end
   end

   initial begin
      leaf_case_type leaf_plan [N_CASES];
      leaf_case_type row;
      octet_q_type   body;
      rsp_type       want;
      logic [31:0]   r;
      logic [20:0]   cp;
      logic [2:0]    kind;
      logic          sized;
      logic [15:0]   dsize;
      int unsigned   pick;
      int unsigned   len;
      int unsigned   cls;
      int unsigned   random_goal;

      leaf_plan = '{
         '{KIND_BOOL,    1'b0, 16'd0,     1,     32'h0000_0000, 1'b1, 1'b1},
         '{KIND_BOOL,    1'b0, 16'd0,     1,     32'h0100_0000, 1'b1, 1'b1},
         '{KIND_BOOL,    1'b1, 16'hFFFF,  1,     32'hFF00_0000, 1'b1, 1'b0},
         '{KIND_BOOL,    1'b0, 16'd0,     2,     32'h0100_0000, 1'b1, 1'b0},
         '{KIND_BOOL,    1'b0, 16'd0,     0,     32'h0000_0000, 1'b1, 1'b0},
         '{KIND_ADDRESS, 1'b0, 16'd0,     20,    32'h00FF_00FF, 1'b1, 1'b1},
         '{KIND_ADDRESS, 1'b1, 16'd20,    19,    32'h0000_0000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     0,     32'h0000_0000, 1'b1, 1'b1},
         '{KIND_STRING,  1'b0, 16'd0,     4,     32'h2041_7E20, 1'b0, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     1,     32'h1F00_0000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     1,     32'h7F00_0000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     2,     32'hC280_0000, 1'b0, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     2,     32'hC0AF_0000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     3,     32'hE09F_BF00, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     3,     32'hEDA0_8000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     3,     32'hEFBF_BF00, 1'b0, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     4,     32'hF08F_BFBF, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     4,     32'hF48F_BFBF, 1'b0, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     4,     32'hF490_8080, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     2,     32'hE282_0000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     2,     32'hC341_0000, 1'b1, 1'b0},
         '{KIND_STRING,  1'b0, 16'd0,     1,     32'h8000_0000, 1'b1, 1'b0},
         '{KIND_BYTES,   1'b0, 16'hFFFF,  0,     32'h0000_0000, 1'b1, 1'b1},
         '{KIND_BYTES,   1'b1, 16'd0,     0,     32'h0000_0000, 1'b1, 1'b1},
         '{KIND_BYTES,   1'b1, 16'd3,     4,     32'hDEAD_BEEF, 1'b1, 1'b0},
         '{KIND_BYTES,   1'b0, 16'd0,     MAX_LEAF,     32'h0, 1'b0, 1'b0},
         '{KIND_BYTES,   1'b0, 16'd0,     MAX_LEAF + 1, 32'h0, 1'b0, 1'b0},
         '{KIND_UINT,    1'b1, 16'd32,    32,    32'hFFFF_FFFF, 1'b1, 1'b1},
         '{KIND_UINT,    1'b0, 16'd1,     1,     32'h0000_0000, 1'b1, 1'b0},
         '{KIND_INT,     1'b1, 16'd1,     1,     32'h8000_0000, 1'b1, 1'b1},
         '{KIND_INT,     1'b1, 16'd33,    33,    32'h0000_0000, 1'b1, 1'b0},
         '{KIND_SPARE_6, 1'b0, 16'd0,     1,     32'h0000_0000, 1'b1, 1'b0},
         '{KIND_SPARE_7, 1'b1, 16'd1,     0,     32'h0000_0000, 1'b1, 1'b0},
         // counter at its top without overflow, then two bytes past it
         '{KIND_BYTES,   1'b1, 16'hFFFF,  65535, 32'h0000_0000, 1'b1, 1'b1},
         '{KIND_BYTES,   1'b0, 16'd0,     65537, 32'h0000_0000, 1'b1, 1'b0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (leaf_plan[i]) begin
         row = leaf_plan[i];
         body.delete();
         for (int unsigned b = 0; b < row.len; b++)
            body.push_back(b < 4 ? row.lead[31 - 8*b -: 8] : 8'h41);
         want.leaf_ok = row.ok;
         want.leaf_length = (row.len > COUNT_MAX) ? COUNT_MAX : row.len[15:0];
         send_leaf(row.kind, row.sized, row.dsize, body, row.typed, want);
      end

      random_goal = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_goal) begin
         body.delete();
         r = $urandom;
         sized = r[0];
         dsize = r[31:16];
         pick = $urandom_range(0, 15);
         if (pick < 2) begin
            kind = KIND_BOOL;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1;
            repeat (len) begin
               r = $urandom;
               body.push_back(r[7:5] == 3'd0 ? r[15:8] : {7'd0, r[0]});
            end
         end else if (pick < 4) begin
            kind = KIND_ADDRESS;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : 20;
            repeat (len) begin
               r = $urandom;
               body.push_back(r[7:0]);
            end
         end else if (pick < 8) begin
            kind = KIND_STRING;
            repeat ($urandom_range(0, 8)) begin
               r = $urandom;
               cls = $urandom_range(0, 19);
               if (cls < 8)
                  cp = 21'($urandom_range('h20, 'h7E));
               else if (cls < 11)
                  cp = 21'($urandom_range('h80, 'h7FF));
               else if (cls < 14)
                  cp = 21'($urandom_range('h800, 'hFFFF));
               else if (cls < 17)
                  cp = 21'($urandom_range('h10000, 'h13FFFF));
               if (cls == 17) begin
                  body.push_back(r[7:0]);
               end else if (cls == 18) begin
                  // overlong two-byte form of an ASCII character
                  body.push_back({7'b1100000, r[0]});
                  body.push_back({2'b10, r[6:1]});
               end else if (cls == 19) begin
                  body.push_back(r[0] ? 8'h7F : {3'b000, r[5:1]});
               end else if (cp < CP_MIN_2) begin
                  body.push_back(cp[7:0]);
               end else if (cp < CP_MIN_3) begin
                  body.push_back({3'b110, cp[10:6]});
                  body.push_back({2'b10, cp[5:0]});
               end else if (cp < CP_MIN_4) begin
                  body.push_back({4'b1110, cp[15:12]});
                  body.push_back({2'b10, cp[11:6]});
                  body.push_back({2'b10, cp[5:0]});
               end else begin
                  body.push_back({5'b11110, cp[20:18]});
                  body.push_back({2'b10, cp[17:12]});
                  body.push_back({2'b10, cp[11:6]});
                  body.push_back({2'b10, cp[5:0]});
               end
            end
            // chop the tail now and then to leave a sequence open
            if (body.size() != 0 && $urandom_range(0, 9) == 0)
               void'(body.pop_back());
         end else if (pick < 11) begin
            kind = KIND_BYTES;
            if (sized && $urandom_range(0, 7) != 0)
               dsize = 16'($urandom_range(0, 24));
            if (sized)
               len = (dsize <= 24 && $urandom_range(0, 4) != 0) ? {16'd0, dsize}
                                                                : $urandom_range(0, 24);
            else
               len = $urandom_range(0, 40);
            repeat (len) begin
               r = $urandom;
               body.push_back(r[7:0]);
            end
         end else if (pick < 15) begin
            kind = (pick < 13) ? KIND_UINT : KIND_INT;
            sized = $urandom_range(0, 7) != 0;
            case ($urandom_range(0, 11))
               0: dsize = 16'd0;
               1: dsize = 16'd33;
               2: dsize = r[31:16];
               default: dsize = 16'($urandom_range(1, 32));
            endcase
            len = (dsize <= 34 && $urandom_range(0, 4) != 0) ? {16'd0, dsize}
                                                             : $urandom_range(0, 34);
            repeat (len) begin
               r = $urandom;
               body.push_back(r[7:0]);
            end
         end else begin
            kind = r[1] ? KIND_SPARE_7 : KIND_SPARE_6;
            repeat ($urandom_range(0, 4)) begin
               r = $urandom;
               body.push_back(r[7:0]);
            end
         end
         send_leaf(kind, sized, dsize, body, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (verdicts_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
